>>> sv/estm_pkg.sv
// Shared types, widths and constants for the Euler scale/translate matrix unit.
// Holds the quarter-wave sine table generator evaluated at elaboration.
// No dependencies.
package estm_pkg;

    localparam int SINE_INDEX_BITS_DEF = 12;
    localparam int FRAC_BITS = 16;

    localparam int MAG_W = 16;
    localparam int TRIG_W = 17;
    localparam int PAIR_W = 32;
    localparam int E45_W = 48;
    localparam int E30_W = 33;
    localparam int PROD_W = 65;
    localparam int ELEM_W = 32;
    localparam int ANGLE_W = 16;
    localparam int MAT_ELEMS = 9;
    localparam int MAT_DIM = 3;

    // Register stages from the input beat to the finished matrix.
    localparam int PIPE_DEPTH = 6;
    // Stage at which the scale meets the rounded rotation terms.
    localparam int SCALE_DEPTH = 4;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [MAG_W-1:0] ONE_Q15 = 16'd32768;

    typedef logic signed [TRIG_W-1:0] trig_val_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [E45_W-1:0] e45_t;
    typedef logic signed [E30_W-1:0] e30_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        elem_t x;
        elem_t y;
        elem_t z;
    } vec3_t;

    typedef struct packed {
        logic sin_neg;
        logic cos_neg;
        logic [MAG_W-1:0] sin_mag;
        logic [MAG_W-1:0] cos_mag;
    } trig_t;

    // Quarter-wave sine magnitude in Q1.15 for entry k of a table with
    // 2^qb steps per quarter turn, from an eleven-term Taylor series in Q30.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                     input int unsigned qb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        logic [MAG_W-1:0] res;
        res = '0;
        if (k == 0) begin
            res = '0;
        end else if (k >= (32'd1 << qb)) begin
            res = ONE_Q15;
        end else begin
            x = (HALF_PI_Q30 * 64'(k)) >> qb;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            term = ((term * x2) >> 30) / 6;   sum = sum - term;
            term = ((term * x2) >> 30) / 20;  sum = sum + term;
            term = ((term * x2) >> 30) / 42;  sum = sum - term;
            term = ((term * x2) >> 30) / 72;  sum = sum + term;
            term = ((term * x2) >> 30) / 110; sum = sum - term;
            term = ((term * x2) >> 30) / 156; sum = sum + term;
            term = ((term * x2) >> 30) / 210; sum = sum - term;
            term = ((term * x2) >> 30) / 272; sum = sum + term;
            term = ((term * x2) >> 30) / 342; sum = sum - term;
            term = ((term * x2) >> 30) / 420; sum = sum + term;
            r = (sum + 64'd16384) >> 15;
            if (r > 64'(ONE_Q15)) begin
                r = 64'(ONE_Q15);
            end
            res = r[MAG_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> sv/euler_scale_translate_matrix_unit.sv
// Top level of the Euler-angle model matrix builder with scale and translation.
// Instantiates estm_sine_rom, estm_rot_pipe, estm_scale_sat and estm_row_ser.
// Depends on estm_pkg.
//
//   Channel  | Direction | Beat contents
//   ---------+-----------+-------------------------------------------------------
//   s_axis   | in        | one pose: position, pitch/yaw/roll angles, axis scale
//   m_axis   | out       | one matrix row; four beats per pose, tlast on row 3
//
// Each accepted pose produces four output beats, one per cycle while the
// consumer is ready; the row serializer at the output limits the pose rate,
// though it loads the next matrix as the last row of the current one is taken.
// The first row passes six pipeline stages and then the output register.
// Reset (aresetn low, synchronous) clears the pipeline valid bits and the
// serializer state; data registers are not reset. A stall on m_axis holds
// the pipeline in place without losing or repeating any pose.
module euler_scale_translate_matrix_unit #(
    parameter int SINE_INDEX_BITS = estm_pkg::SINE_INDEX_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], pitch_angle[111:96],
    // yaw_angle[127:112], roll_angle[143:128], scale_x[175:144],
    // scale_y[207:176], scale_z[239:208]
    input  logic [239:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // elem_col0[31:0], elem_col1[63:32], elem_col2[95:64], elem_col3[127:96]
    output logic [127:0]  m_axis_tdata,
    // row_index[1:0]
    output logic [1:0]    m_axis_tuser,
    // last_row
    output logic          m_axis_tlast
);

    localparam int PD = estm_pkg::PIPE_DEPTH;
    localparam int SD = estm_pkg::SCALE_DEPTH;

    // Unpacked input fields.
    estm_pkg::vec3_t              pos_in;
    estm_pkg::vec3_t              scale_in;
    logic [estm_pkg::ANGLE_W-1:0] pitch_angle;
    logic [estm_pkg::ANGLE_W-1:0] yaw_angle;
    logic [estm_pkg::ANGLE_W-1:0] roll_angle;

    assign pos_in.x    = s_axis_tdata[31:0];
    assign pos_in.y    = s_axis_tdata[63:32];
    assign pos_in.z    = s_axis_tdata[95:64];
    assign pitch_angle = s_axis_tdata[111:96];
    assign yaw_angle   = s_axis_tdata[127:112];
    assign roll_angle  = s_axis_tdata[143:128];
    assign scale_in.x  = s_axis_tdata[175:144];
    assign scale_in.y  = s_axis_tdata[207:176];
    assign scale_in.z  = s_axis_tdata[239:208];

    // The whole pipeline moves together: it advances whenever its last stage
    // is empty or the serializer is taking that stage's matrix this cycle.
    logic             pipe_en;
    logic             ser_ready;
    logic [PD-1:0]    valid_reg, valid_next;

    estm_pkg::vec3_t  pos_dly_reg   [PD];
    estm_pkg::vec3_t  scale_dly_reg [SD];

    estm_pkg::trig_t  pitch_trig, yaw_trig, roll_trig;
    estm_pkg::e30_t   e30_terms [estm_pkg::MAT_ELEMS];
    estm_pkg::elem_t  mat_elems [estm_pkg::MAT_ELEMS];

    assign pipe_en = !valid_reg[PD-1] || ser_ready;
    assign s_axis_tready = pipe_en;

    always_comb begin
        valid_next = valid_reg;
        if (pipe_en) begin
            valid_next = {valid_reg[PD-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Position and scale ride alongside the arithmetic until they are used.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pos_dly_reg[0] <= pos_in;
            for (int i = 1; i < PD; i++) begin
                pos_dly_reg[i] <= pos_dly_reg[i-1];
            end
            scale_dly_reg[0] <= scale_in;
            for (int i = 1; i < SD; i++) begin
                scale_dly_reg[i] <= scale_dly_reg[i-1];
            end
        end
    end

    // Stage 1: sine and cosine of each angle.
    estm_sine_rom #(
        .IDX_BITS (SINE_INDEX_BITS)
    ) u_pitch_rom (
        .aclk  (aclk),
        .en    (pipe_en),
        .angle (pitch_angle),
        .trig  (pitch_trig)
    );

    estm_sine_rom #(
        .IDX_BITS (SINE_INDEX_BITS)
    ) u_yaw_rom (
        .aclk  (aclk),
        .en    (pipe_en),
        .angle (yaw_angle),
        .trig  (yaw_trig)
    );

    estm_sine_rom #(
        .IDX_BITS (SINE_INDEX_BITS)
    ) u_roll_rom (
        .aclk  (aclk),
        .en    (pipe_en),
        .angle (roll_angle),
        .trig  (roll_trig)
    );

    // Stages 2 to 4: rotation terms rounded to Q30.
    estm_rot_pipe u_rot_pipe (
        .aclk       (aclk),
        .en         (pipe_en),
        .pitch_trig (pitch_trig),
        .yaw_trig   (yaw_trig),
        .roll_trig  (roll_trig),
        .e30_out    (e30_terms)
    );

    // Stages 5 and 6: per-column scale, rounding and saturation.
    estm_scale_sat u_scale_sat (
        .aclk     (aclk),
        .en       (pipe_en),
        .e30_in   (e30_terms),
        .scale    (scale_dly_reg[SD-1]),
        .elem_out (mat_elems)
    );

    // Output: four row beats per matrix.
    estm_row_ser u_row_ser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .mat_valid     (valid_reg[PD-1]),
        .mat_ready     (ser_ready),
        .mat_in        (mat_elems),
        .pos_in        (pos_dly_reg[PD-1]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> sv/estm_sine_rom.sv
// Registered sine and cosine lookup for one 16-bit binary angle.
// Quarter-wave constant table built from estm_pkg::quarter_sine.
// Depends on estm_pkg.
module estm_sine_rom #(
    parameter int IDX_BITS = estm_pkg::SINE_INDEX_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [estm_pkg::ANGLE_W-1:0]  angle,
    output estm_pkg::trig_t               trig
);

    localparam int QB = IDX_BITS - 2;
    localparam int QSIZE = 1 << QB;

    logic [estm_pkg::MAG_W-1:0] quarter_tab [QSIZE+1];

    for (genvar k = 0; k <= QSIZE; k++) begin : g_tab
        assign quarter_tab[k] = estm_pkg::quarter_sine(k, QB);
    end

    logic [IDX_BITS-1:0] idx;
    logic [1:0]          sin_quad;
    logic [1:0]          cos_quad;
    logic [QB-1:0]       k_low;
    logic [QB:0]         sin_addr;
    logic [QB:0]         cos_addr;
    estm_pkg::trig_t     trig_reg;

    assign idx = angle[estm_pkg::ANGLE_W-1 -: IDX_BITS];
    assign sin_quad = idx[IDX_BITS-1 -: 2];
    assign cos_quad = sin_quad + 2'd1;
    assign k_low = idx[QB-1:0];

    // Odd quadrants walk the quarter wave backwards.
    assign sin_addr = sin_quad[0] ? ((QB+1)'(QSIZE) - {1'b0, k_low}) : {1'b0, k_low};
    assign cos_addr = cos_quad[0] ? ((QB+1)'(QSIZE) - {1'b0, k_low}) : {1'b0, k_low};

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg.sin_mag <= quarter_tab[sin_addr];
            trig_reg.cos_mag <= quarter_tab[cos_addr];
            trig_reg.sin_neg <= sin_quad[1];
            trig_reg.cos_neg <= cos_quad[1];
        end
    end

    assign trig = trig_reg;

endmodule

>>> sv/estm_rot_pipe.sv
// Rotation term pipeline: pair products, triple products, then rounding to Q30.
// Three register stages driven by a shared advance enable.
// Depends on estm_pkg.
module estm_rot_pipe (
    input  logic              aclk,
    input  logic              en,
    input  estm_pkg::trig_t   pitch_trig,
    input  estm_pkg::trig_t   yaw_trig,
    input  estm_pkg::trig_t   roll_trig,
    output estm_pkg::e30_t    e30_out [estm_pkg::MAT_ELEMS]
);

    localparam int P_C2C3 = 0;
    localparam int P_C1S3 = 1;
    localparam int P_S2C3 = 2;
    localparam int P_C2S3 = 3;
    localparam int P_C1C3 = 4;
    localparam int P_S2S3 = 5;
    localparam int P_C1S2 = 6;
    localparam int P_C1C2 = 7;
    localparam int P_S1S2 = 8;
    localparam int P_S1C2 = 9;
    localparam int NUM_PAIRS = 10;

    localparam int T_00 = 0;
    localparam int T_02 = 1;
    localparam int T_10 = 2;
    localparam int T_12 = 3;
    localparam int NUM_TRI = 4;

    localparam estm_pkg::e45_t RND14 = estm_pkg::E45_W'(1) <<< 14;

    function automatic estm_pkg::trig_val_t to_val(input logic [estm_pkg::MAG_W-1:0] mag,
                                                  input logic neg);
        estm_pkg::trig_val_t v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    function automatic estm_pkg::e45_t sh15(input estm_pkg::pair_t p);
        return estm_pkg::E45_W'(p) <<< 15;
    endfunction

    estm_pkg::trig_val_t s1, c1, s2, c2, s3, c3;
    estm_pkg::trig_val_t op_a [NUM_PAIRS];
    estm_pkg::trig_val_t op_b [NUM_PAIRS];
    logic signed [2*estm_pkg::TRIG_W-1:0] pair_full [NUM_PAIRS];

    estm_pkg::pair_t     pair_reg [NUM_PAIRS];
    estm_pkg::trig_val_t s1_reg, s3_reg, c3_reg;

    logic signed [estm_pkg::PAIR_W+estm_pkg::TRIG_W-1:0] tri_full [NUM_TRI];
    estm_pkg::pair_t     pair_d_reg [NUM_PAIRS];
    estm_pkg::trig_val_t s1_d_reg;
    estm_pkg::e45_t      tri_reg [NUM_TRI];

    estm_pkg::e45_t      e45 [estm_pkg::MAT_ELEMS];
    estm_pkg::e30_t      e30_reg [estm_pkg::MAT_ELEMS];

    assign s1 = to_val(pitch_trig.sin_mag, pitch_trig.sin_neg);
    assign c1 = to_val(pitch_trig.cos_mag, pitch_trig.cos_neg);
    assign s2 = to_val(yaw_trig.sin_mag, yaw_trig.sin_neg);
    assign c2 = to_val(yaw_trig.cos_mag, yaw_trig.cos_neg);
    assign s3 = to_val(roll_trig.sin_mag, roll_trig.sin_neg);
    assign c3 = to_val(roll_trig.cos_mag, roll_trig.cos_neg);

    always_comb begin
        op_a[P_C2C3] = c2; op_b[P_C2C3] = c3;
        op_a[P_C1S3] = c1; op_b[P_C1S3] = s3;
        op_a[P_S2C3] = s2; op_b[P_S2C3] = c3;
        op_a[P_C2S3] = c2; op_b[P_C2S3] = s3;
        op_a[P_C1C3] = c1; op_b[P_C1C3] = c3;
        op_a[P_S2S3] = s2; op_b[P_S2S3] = s3;
        op_a[P_C1S2] = c1; op_b[P_C1S2] = s2;
        op_a[P_C1C2] = c1; op_b[P_C1C2] = c2;
        op_a[P_S1S2] = s1; op_b[P_S1S2] = s2;
        op_a[P_S1C2] = s1; op_b[P_S1C2] = c2;
        for (int i = 0; i < NUM_PAIRS; i++) begin
            pair_full[i] = op_a[i] * op_b[i];
        end
    end

    // Stage 2: two-factor products, each at most one in Q30.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_PAIRS; i++) begin
                pair_reg[i] <= estm_pkg::PAIR_W'(pair_full[i]);
            end
            s1_reg <= s1;
            s3_reg <= s3;
            c3_reg <= c3;
        end
    end

    always_comb begin
        tri_full[T_00] = pair_reg[P_S1S2] * s3_reg;
        tri_full[T_02] = pair_reg[P_S1C2] * s3_reg;
        tri_full[T_10] = pair_reg[P_S1S2] * c3_reg;
        tri_full[T_12] = pair_reg[P_S1C2] * c3_reg;
    end

    // Stage 3: three-factor products in Q45, pairs carried alongside.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_TRI; i++) begin
                tri_reg[i] <= estm_pkg::E45_W'(tri_full[i]);
            end
            for (int i = 0; i < NUM_PAIRS; i++) begin
                pair_d_reg[i] <= pair_reg[i];
            end
            s1_d_reg <= s1_reg;
        end
    end

    always_comb begin
        e45[0] = sh15(pair_d_reg[P_C2C3]) + tri_reg[T_00];
        e45[1] = sh15(pair_d_reg[P_C1S3]);
        e45[2] = tri_reg[T_02] - sh15(pair_d_reg[P_S2C3]);
        e45[3] = tri_reg[T_10] - sh15(pair_d_reg[P_C2S3]);
        e45[4] = sh15(pair_d_reg[P_C1C3]);
        e45[5] = sh15(pair_d_reg[P_S2S3]) + tri_reg[T_12];
        e45[6] = sh15(pair_d_reg[P_C1S2]);
        e45[7] = -(estm_pkg::E45_W'(s1_d_reg) <<< 30);
        e45[8] = sh15(pair_d_reg[P_C1C2]);
    end

    // Stage 4: round half up from Q45 to Q30.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < estm_pkg::MAT_ELEMS; i++) begin
                e30_reg[i] <= estm_pkg::E30_W'((e45[i] + RND14) >>> 15);
            end
        end
    end

    assign e30_out = e30_reg;

endmodule

>>> sv/estm_scale_sat.sv
// Column scaling of the rotation terms with rounding and 32-bit saturation.
// Two register stages: product, then round and clamp.
// Depends on estm_pkg.
module estm_scale_sat (
    input  logic              aclk,
    input  logic              en,
    input  estm_pkg::e30_t    e30_in [estm_pkg::MAT_ELEMS],
    input  estm_pkg::vec3_t   scale,
    output estm_pkg::elem_t   elem_out [estm_pkg::MAT_ELEMS]
);

    localparam int RND_W = estm_pkg::PROD_W - 30;
    localparam estm_pkg::prod_t RND30 = estm_pkg::PROD_W'(1) <<< 29;
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32'sh7FFF_FFFF);
    localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(32'sh8000_0000);

    estm_pkg::elem_t  col_scale [estm_pkg::MAT_DIM];
    estm_pkg::prod_t  prod_next [estm_pkg::MAT_ELEMS];
    estm_pkg::prod_t  prod_reg  [estm_pkg::MAT_ELEMS];
    estm_pkg::prod_t  rsum      [estm_pkg::MAT_ELEMS];
    logic signed [RND_W-1:0] rnd [estm_pkg::MAT_ELEMS];
    estm_pkg::elem_t  sat_next  [estm_pkg::MAT_ELEMS];
    estm_pkg::elem_t  elem_reg  [estm_pkg::MAT_ELEMS];

    assign col_scale[0] = scale.x;
    assign col_scale[1] = scale.y;
    assign col_scale[2] = scale.z;

    always_comb begin
        for (int r = 0; r < estm_pkg::MAT_DIM; r++) begin
            for (int c = 0; c < estm_pkg::MAT_DIM; c++) begin
                prod_next[r*estm_pkg::MAT_DIM + c] = e30_in[r*estm_pkg::MAT_DIM + c] * col_scale[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        for (int i = 0; i < estm_pkg::MAT_ELEMS; i++) begin
            rsum[i] = prod_reg[i] + RND30;
            rnd[i] = RND_W'(rsum[i] >>> 30);
            if (rnd[i] > SAT_HI) begin
                sat_next[i] = estm_pkg::ELEM_W'(SAT_HI);
            end else if (rnd[i] < SAT_LO) begin
                sat_next[i] = estm_pkg::ELEM_W'(SAT_LO);
            end else begin
                sat_next[i] = estm_pkg::ELEM_W'(rnd[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            elem_reg <= sat_next;
        end
    end

    assign elem_out = elem_reg;

endmodule

>>> sv/estm_row_ser.sv
// Output stage: holds one finished matrix and sends it as four row beats.
// Also acts as the output register between the pipeline and the consumer.
// Depends on estm_pkg.
module estm_row_ser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              mat_valid,
    output logic              mat_ready,
    input  estm_pkg::elem_t   mat_in [estm_pkg::MAT_ELEMS],
    input  estm_pkg::vec3_t   pos_in,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [127:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam logic [1:0] ROW_0 = 2'd0;
    localparam logic [1:0] ROW_1 = 2'd1;
    localparam logic [1:0] ROW_2 = 2'd2;
    localparam logic [1:0] ROW_3 = 2'd3;

    localparam estm_pkg::elem_t ONE_Q = estm_pkg::elem_t'(32'sd1 <<< estm_pkg::FRAC_BITS);
    localparam estm_pkg::elem_t ZERO_Q = '0;

    logic             busy_reg, busy_next;
    logic [1:0]       row_reg, row_next;
    estm_pkg::elem_t  mat_reg [estm_pkg::MAT_ELEMS];
    estm_pkg::vec3_t  pos_reg;
    logic             take;
    logic             on_last;
    logic             load;

    assign take = busy_reg && m_axis_tready;
    assign on_last = (row_reg == ROW_3);
    assign mat_ready = !busy_reg || (take && on_last);
    assign load = mat_valid && mat_ready;

    always_comb begin
        busy_next = busy_reg;
        row_next = row_reg;
        if (load) begin
            busy_next = 1'b1;
            row_next = ROW_0;
        end else if (take) begin
            busy_next = !on_last;
            row_next = row_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg <= ROW_0;
        end else begin
            busy_reg <= busy_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mat_reg <= mat_in;
            pos_reg <= pos_in;
        end
    end

    always_comb begin
        unique case (row_reg)
            ROW_0: m_axis_tdata = {ZERO_Q, mat_reg[2], mat_reg[1], mat_reg[0]};
            ROW_1: m_axis_tdata = {ZERO_Q, mat_reg[5], mat_reg[4], mat_reg[3]};
            ROW_2: m_axis_tdata = {ZERO_Q, mat_reg[8], mat_reg[7], mat_reg[6]};
            ROW_3: m_axis_tdata = {ONE_Q, pos_reg.z, pos_reg.y, pos_reg.x};
        endcase
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tuser = row_reg;
    assign m_axis_tlast = on_last;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for euler_scale_translate_matrix_unit: drives poses on
// s_axis and checks every matrix row on m_axis against an in-bench predictor.
// Depends on estm_pkg and the RTL of the unit; needs nothing else.
module tb_top;

    localparam int IDX_BITS = estm_pkg::SINE_INDEX_BITS_DEF;
    localparam int QTR_BITS = IDX_BITS - 2;
    localparam int QTR = 1 << QTR_BITS;
    localparam int ANGLE_SHIFT = 16 - IDX_BITS;
    localparam logic signed [31:0] ONE_FIX = 32'sd1 <<< estm_pkg::FRAC_BITS;
    localparam logic signed [31:0] MAX_FIX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_FIX = 32'sh8000_0000;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [15:0] HALF_TURN = 16'h8000;
    localparam logic [15:0] THREE_QUARTER_TURN = 16'hC000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 16;
    localparam int MAX_PRINTED = 60;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [15:0] roll;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } pose_t;

    typedef struct packed {
        logic [1:0] row_index;
        logic [31:0] col0;
        logic [31:0] col1;
        logic [31:0] col2;
        logic [31:0] col3;
        logic last_row;
    } matrix_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [239:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;

    // Idle chances in percent for the pose sender and the row receiver.
    int send_idle_pct = 36;
    int recv_stall_pct = 48;
    int mismatch_count = 0;

    // Quarter-wave magnitudes in Q1.15, entry QTR holds exactly one.
    longint sine_mag[0:QTR];
    // Rows still owed by the unit, oldest first.
    matrix_row_t rows_due[$];

    euler_scale_translate_matrix_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Taylor series of sin(pi/2 * k / QTR) in Q30, rounded half up to Q1.15.
    function automatic longint quarter_wave(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        longint unsigned kk;
        int n;
        kk = longint'(k);
        if (k == 0) begin
            return 0;
        end
        if (k >= QTR) begin
            return 32768;
        end
        x = (64'd1686629713 * kk) >> QTR_BITS;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return longint'(r);
    endfunction

    // Signed sine in Q1.15 for a table index; the top two bits pick the quadrant.
    function automatic longint sine_of(input int unsigned idx);
        int unsigned quad;
        int unsigned k;
        longint mag;
        idx = idx & ((1 << IDX_BITS) - 1);
        quad = idx >> QTR_BITS;
        k = idx & (QTR - 1);
        mag = quad[0] ? sine_mag[QTR - k] : sine_mag[k];
        return quad[1] ? -mag : mag;
    endfunction

    // Rounds a Q45 rotation term to Q30, applies the Q16.16 scale and clamps.
    function automatic logic [31:0] scaled_term(input longint e45, input longint scale);
        longint e30;
        longint p;
        e30 = (e45 + (longint'(1) <<< 14)) >>> 15;
        p = (e30 * scale + (longint'(1) <<< 29)) >>> 30;
        if (p > longint'(MAX_FIX)) begin
            p = longint'(MAX_FIX);
        end
        if (p < longint'(MIN_FIX)) begin
            p = longint'(MIN_FIX);
        end
        return p[31:0];
    endfunction

    // Works out the four rows that one pose must produce and queues them.
    function automatic void predict_matrix_rows(input pose_t p);
        longint s1, c1, s2, c2, s3, c3;
        longint rot[3][3];
        longint sc[3];
        longint q15;
        longint q30;
        int unsigned ia;
        matrix_row_t row;
        int r;
        q15 = longint'(1) <<< 15;
        q30 = longint'(1) <<< 30;
        ia = p.pitch >> ANGLE_SHIFT;
        s1 = sine_of(ia);
        c1 = sine_of(ia + QTR);
        ia = p.yaw >> ANGLE_SHIFT;
        s2 = sine_of(ia);
        c2 = sine_of(ia + QTR);
        ia = p.roll >> ANGLE_SHIFT;
        s3 = sine_of(ia);
        c3 = sine_of(ia + QTR);
        rot[0][0] = c2 * c3 * q15 + s1 * s2 * s3;
        rot[0][1] = c1 * s3 * q15;
        rot[0][2] = -s2 * c3 * q15 + s1 * c2 * s3;
        rot[1][0] = -c2 * s3 * q15 + s1 * s2 * c3;
        rot[1][1] = c1 * c3 * q15;
        rot[1][2] = s2 * s3 * q15 + s1 * c2 * c3;
        rot[2][0] = c1 * s2 * q15;
        rot[2][1] = -s1 * q30;
        rot[2][2] = c1 * c2 * q15;
        sc[0] = p.scale_x;
        sc[1] = p.scale_y;
        sc[2] = p.scale_z;
        for (r = 0; r < 3; r++) begin
            row.row_index = 2'(r);
            row.col0 = scaled_term(rot[r][0], sc[0]);
            row.col1 = scaled_term(rot[r][1], sc[1]);
            row.col2 = scaled_term(rot[r][2], sc[2]);
            row.col3 = '0;
            row.last_row = 1'b0;
            rows_due.push_back(row);
        end
        // The translation row passes the position through and closes the matrix.
        row.row_index = 2'd3;
        row.col0 = p.pos_x;
        row.col1 = p.pos_y;
        row.col2 = p.pos_z;
        row.col3 = ONE_FIX;
        row.last_row = 1'b1;
        rows_due.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Offers one pose and holds it until the unit takes the beat. The valid
    // bit is left high so that back-to-back poses need no extra assignment.
    task automatic send_pose(input pose_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.scale_z, p.scale_y, p.scale_x, p.roll, p.yaw, p.pitch,
                         p.pos_z, p.pos_y, p.pos_x};
        do @(posedge aclk); while (!s_axis_tready);
        predict_matrix_rows(p);
    endtask

    // Stops offering poses until every owed row has come out.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (rows_due.size() != 0);
    endtask

    function automatic pose_t unit_pose();
        pose_t p;
        p = '0;
        p.scale_x = ONE_FIX;
        p.scale_y = ONE_FIX;
        p.scale_z = ONE_FIX;
        return p;
    endfunction

    function automatic logic [31:0] random_scale();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1: v = $urandom;
            2: begin
                case ($urandom_range(4))
                    0: v = MAX_FIX;
                    1: v = MIN_FIX;
                    2: v = ONE_FIX;
                    3: v = -ONE_FIX;
                    default: v = '0;
                endcase
            end
            // Most scales stay within plus or minus eight so the rotation shows.
            default: v = 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] random_angle();
        logic [15:0] a;
        if ($urandom_range(5) == 0) begin
            // Near a quadrant boundary, where the table folds over.
            a = {2'($urandom_range(3)), 14'h0} + 16'($urandom_range(0, 40)) - 16'd20;
        end else begin
            a = 16'($urandom_range(65535));
        end
        return a;
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        p.pos_x = $urandom;
        p.pos_y = $urandom;
        p.pos_z = $urandom;
        p.pitch = random_angle();
        p.yaw = random_angle();
        p.roll = random_angle();
        p.scale_x = random_scale();
        p.scale_y = random_scale();
        p.scale_z = random_scale();
        return p;
    endfunction

    task automatic test_identity_pose();
        send_pose(unit_pose());
    endtask

    // A quarter, half and three-quarter turn on each axis on its own.
    task automatic test_quadrant_angles();
        pose_t p;
        logic [15:0] turns[3];
        int axis;
        int t;
        turns[0] = QUARTER_TURN;
        turns[1] = HALF_TURN;
        turns[2] = THREE_QUARTER_TURN;
        for (axis = 0; axis < 3; axis++) begin
            for (t = 0; t < 3; t++) begin
                p = unit_pose();
                case (axis)
                    0: p.pitch = turns[t];
                    1: p.yaw = turns[t];
                    default: p.roll = turns[t];
                endcase
                send_pose(p);
            end
        end
    endtask

    // Angle bits below the table index must make no difference.
    task automatic test_ignored_angle_bits();
        pose_t p;
        p = unit_pose();
        p.pitch = 16'h000F;
        p.yaw = 16'hFFFF;
        p.roll = 16'h3FFF;
        send_pose(p);
        p.pitch = 16'hFFFF;
        p.yaw = 16'h400F;
        p.roll = 16'h000F;
        send_pose(p);
        p.pitch = 16'h7FFF;
        p.yaw = 16'hBFFF;
        p.roll = 16'hC00F;
        send_pose(p);
    endtask

    task automatic test_position_extremes();
        pose_t p;
        p = unit_pose();
        p.pos_x = MAX_FIX;
        p.pos_y = MIN_FIX;
        p.pos_z = '1;
        send_pose(p);
        p.pos_x = MIN_FIX;
        p.pos_y = '0;
        p.pos_z = MAX_FIX;
        send_pose(p);
    endtask

    // Clamping at both ends of the 32-bit range, and the exact boundary values.
    task automatic test_saturation();
        pose_t p;
        int k;
        int pick;
        longint norm;
        // Yaw of half a turn gives -1 in column 0 and the minimum scale
        // overflows upward; +1 times the minimum lands exactly on the bound.
        p = unit_pose();
        p.yaw = HALF_TURN;
        p.scale_x = MIN_FIX;
        p.scale_y = MIN_FIX;
        p.scale_z = MAX_FIX;
        send_pose(p);
        p.pitch = QUARTER_TURN;
        p.scale_y = MIN_FIX;
        p.scale_z = MIN_FIX;
        send_pose(p);
        // With pitch at a quarter turn and equal yaw and roll, row 0 column 0
        // is cos^2 + sin^2 from rounded table values, which can exceed one.
        pick = 0;
        for (k = 1; k < QTR; k++) begin
            norm = sine_mag[k] * sine_mag[k] + sine_mag[QTR - k] * sine_mag[QTR - k];
            if (pick == 0 && norm > (longint'(1) <<< 30)) begin
                pick = k;
            end
        end
        if (pick == 0) begin
            pick = QTR / 2;
        end
        p = unit_pose();
        p.pitch = QUARTER_TURN;
        p.yaw = 16'(pick << ANGLE_SHIFT);
        p.roll = 16'(pick << ANGLE_SHIFT);
        p.scale_x = MIN_FIX;
        send_pose(p);
        p.scale_x = MAX_FIX;
        send_pose(p);
    endtask

    task automatic test_random_poses(input int count, input int send_pct, input int recv_pct);
        int i;
        hold_until_drained();
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (i = 0; i < count; i++) begin
            send_pose(random_pose());
        end
    endtask

    // The receiver stalls at random, at the rate the current phase sets.
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each row beat is compared field by field with the oldest owed row.
    always @(posedge aclk) begin : row_checker
        matrix_row_t got;
        matrix_row_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.row_index = m_axis_tuser;
            got.col0 = m_axis_tdata[31:0];
            got.col1 = m_axis_tdata[63:32];
            got.col2 = m_axis_tdata[95:64];
            got.col3 = m_axis_tdata[127:96];
            got.last_row = m_axis_tlast;
            if (rows_due.size() == 0) begin
                report_mismatch("row beat with nothing owed", got.col0, '0);
            end else begin
                want = rows_due.pop_front();
                if (got.row_index != want.row_index) begin
                    report_mismatch("row_index", got.row_index, want.row_index);
                end
                if (got.col0 != want.col0) begin
                    report_mismatch("elem_col0", got.col0, want.col0);
                end
                if (got.col1 != want.col1) begin
                    report_mismatch("elem_col1", got.col1, want.col1);
                end
                if (got.col2 != want.col2) begin
                    report_mismatch("elem_col2", got.col2, want.col2);
                end
                if (got.col3 != want.col3) begin
                    report_mismatch("elem_col3", got.col3, want.col3);
                end
                if (got.last_row != want.last_row) begin
                    report_mismatch("last_row", got.last_row, want.last_row);
                end
            end
        end
    end

    initial begin : stimulus
        int k;
        int waited;
        for (k = 0; k <= QTR; k++) begin
            sine_mag[k] = quarter_wave(k);
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_identity_pose();
        test_quadrant_angles();
        test_ignored_angle_bits();
        test_position_extremes();
        test_saturation();

        // Each phase first waits until the unit has emptied.
        test_random_poses(87, 36, 48);
        test_random_poses(87, 48, 36);
        test_random_poses(86, 0, 0);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (rows_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (rows_due.size() != 0) begin
            report_mismatch("rows never delivered", rows_due.size(), '0);
        end
        // Any stray beat after the last owed row is caught by the checker.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("euler_scale_translate_matrix_unit regression: pass");
        end else begin
            $display("euler_scale_translate_matrix_unit regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("euler_scale_translate_matrix_unit regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
sv/estm_pkg.sv
sv/estm_sine_rom.sv
sv/estm_rot_pipe.sv
sv/estm_scale_sat.sv
sv/estm_row_ser.sv
sv/euler_scale_translate_matrix_unit.sv
tb/tb_top.sv
